FILE: src/rme_pkg.sv
package rme_pkg;

    // default data path width
    localparam int WORD_WIDTH_DEF = 20;

    // configuration register index
    localparam int CFG_INDEX_WIDTH = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_EXPONENT = 2'd0,
        REG_MODULUS  = 2'd1
    } cfg_reg_t;

    // register reset values, cut to the word width where used
    localparam logic [63:0] EXPONENT_RESET = 64'd65537;
    localparam logic [63:0] MODULUS_RESET  = 64'd1048573;

    // controller to datapath
    typedef struct packed {
        logic load;          // capture base, exponent, seed accumulator
        logic start_reduce;  // reduce base modulo modulus
        logic take_base;     // store reduced base
        logic start_step;    // start multiply and square together
        logic step_update;   // retire one exponent bit
        logic out_load;      // move accumulator to output register
    } rme_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic e_zero;     // remaining exponent is zero
        logic e_last;     // remaining exponent has no bit above bit 0
        logic m_small;    // modulus below two
        logic lane_done;  // square lane finished
        logic mul_done;   // multiply lane finished
    } rme_stat_t;

endpackage

FILE: src/rme_mulmod.sv
module rme_mulmod #(
    parameter int WORD_WIDTH = rme_pkg::WORD_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [WORD_WIDTH-1:0] a,
    input  logic [WORD_WIDTH-1:0] b,
    input  logic [WORD_WIDTH-1:0] m,
    output logic                  done,
    output logic [WORD_WIDTH-1:0] result
);
    import rme_pkg::*;

    // interleaved modular multiply, one bit of a per cycle, msb first
    // needs b < m and m >= 2
    localparam int CNT_W = (WORD_WIDTH > 1) ? $clog2(WORD_WIDTH) : 1;
    localparam int SUM_W = WORD_WIDTH + 2;

    logic [WORD_WIDTH-1:0] a_reg;
    logic [WORD_WIDTH-1:0] b_reg;
    logic [WORD_WIDTH-1:0] m_reg;
    logic [WORD_WIDTH-1:0] r_reg;
    logic [WORD_WIDTH-1:0] r_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] m1;
    logic [SUM_W-1:0] m2;
    logic [SUM_W-1:0] sub;

    always_comb
    begin
        sum = {1'b0, r_reg, 1'b0}
            + (a_reg[WORD_WIDTH-1] ? {2'b00, b_reg} : '0);
        m1  = {2'b00, m_reg};
        m2  = {1'b0, m_reg, 1'b0};
        if (sum >= m2)
        begin
            sub = sum - m2;
        end
        else if (sum >= m1)
        begin
            sub = sum - m1;
        end
        else
        begin
            sub = sum;
        end
        r_next = sub[WORD_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WORD_WIDTH - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            m_reg <= m;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            a_reg <= {a_reg[WORD_WIDTH-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("mulmod not busy after start");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("mulmod done without a finished run");

    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (r_reg < m_reg))
        else $error("mulmod result not below modulus");
`endif

endmodule

FILE: src/rme_datapath.sv
module rme_datapath #(
    parameter int WORD_WIDTH = rme_pkg::WORD_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rme_pkg::rme_cmd_t      cmd,
    output rme_pkg::rme_stat_t     stat,
    input  logic [WORD_WIDTH-1:0]  exponent,
    input  logic [WORD_WIDTH-1:0]  modulus,
    input  logic [WORD_WIDTH-1:0]  base_value,
    output logic [WORD_WIDTH-1:0]  result_value
);
    import rme_pkg::*;

    localparam logic [WORD_WIDTH-1:0] ONE = WORD_WIDTH'(1);

    logic [WORD_WIDTH-1:0] base_reg;
    logic [WORD_WIDTH-1:0] e_reg;
    logic [WORD_WIDTH-1:0] acc_reg;
    logic [WORD_WIDTH-1:0] b_reg;
    logic [WORD_WIDTH-1:0] out_data_reg;

    logic                  m_small;
    logic [WORD_WIDTH-1:0] sq_a;
    logic [WORD_WIDTH-1:0] sq_b;
    logic [WORD_WIDTH-1:0] mul_res;
    logic [WORD_WIDTH-1:0] sq_res;
    logic                  sq_done;
    logic                  mul_done;

    assign m_small = (modulus[WORD_WIDTH-1:1] == '0);

    // square lane also reduces the incoming base (base * 1 mod m)
    assign sq_a = cmd.start_reduce ? base_reg : b_reg;
    assign sq_b = cmd.start_reduce ? ONE : b_reg;

    rme_mulmod #(.WORD_WIDTH(WORD_WIDTH)) u_mul_lane (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start_step),
        .a      (acc_reg),
        .b      (b_reg),
        .m      (modulus),
        .done   (mul_done),
        .result (mul_res)
    );

    rme_mulmod #(.WORD_WIDTH(WORD_WIDTH)) u_sq_lane (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start_reduce | cmd.start_step),
        .a      (sq_a),
        .b      (sq_b),
        .m      (modulus),
        .done   (sq_done),
        .result (sq_res)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg <= base_value;
            e_reg    <= exponent;
            // exponent zero gives 1, tiny modulus gives 0
            acc_reg  <= (m_small && (exponent != '0)) ? '0 : ONE;
        end
        else if (cmd.step_update)
        begin
            if (e_reg[0])
            begin
                acc_reg <= mul_res;
            end
            b_reg <= sq_res;
            e_reg <= {1'b0, e_reg[WORD_WIDTH-1:1]};
        end
        else if (cmd.take_base)
        begin
            b_reg <= sq_res;
        end

        if (cmd.out_load)
        begin
            out_data_reg <= acc_reg;
        end
    end

    always_comb
    begin
        stat.e_zero    = (e_reg == '0);
        stat.e_last    = (e_reg[WORD_WIDTH-1:1] == '0);
        stat.m_small   = m_small;
        stat.lane_done = sq_done;
        stat.mul_done  = mul_done;
    end

    assign result_value = out_data_reg;

endmodule

FILE: src/rme_ctrl.sv
module rme_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  rme_pkg::rme_stat_t stat,
    output rme_pkg::rme_cmd_t  cmd
);
    import rme_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_CHECK    = 7'b0000010,
        ST_RED_GO   = 7'b0000100,
        ST_RED_WAIT = 7'b0001000,
        ST_SQ_GO    = 7'b0010000,
        ST_SQ_WAIT  = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.e_zero || stat.m_small)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_RED_GO;
                end
            end
            ST_RED_GO:
            begin
                cmd.start_reduce = 1'b1;
                state_next       = ST_RED_WAIT;
            end
            ST_RED_WAIT:
            begin
                if (stat.lane_done)
                begin
                    cmd.take_base = 1'b1;
                    state_next    = ST_SQ_GO;
                end
            end
            ST_SQ_GO:
            begin
                cmd.start_step = 1'b1;
                state_next     = ST_SQ_WAIT;
            end
            ST_SQ_WAIT:
            begin
                // both lanes run the same length and finish together
                if (stat.lane_done && stat.mul_done)
                begin
                    cmd.step_update = 1'b1;
                    state_next      = stat.e_last ? ST_DONE : ST_SQ_GO;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: src/rsa_modular_exponentiation.sv
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall   | base_value
// out     | output    | out_valid/out_stall | result_value
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one item at a time: a new base is taken only while the sequencer is idle; each item runs a
// base reduce, then one step per exponent bit up to the top set bit, in the bit-serial multiply
// lanes (one bit per cycle); exponent zero or modulus below two skip the reduce and the steps
// rst_n is asynchronous active low; config returns to exponent 65537, modulus 1048573
// the output register lets a new item enter while a result waits under out_stall
module rsa_modular_exponentiation #(
    parameter int WORD_WIDTH = rme_pkg::WORD_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [WORD_WIDTH-1:0]              base_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [WORD_WIDTH-1:0]              result_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rme_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [WORD_WIDTH-1:0]              cfg_data
);
    import rme_pkg::*;

    logic [WORD_WIDTH-1:0] exponent_reg;
    logic [WORD_WIDTH-1:0] modulus_reg;
    rme_cmd_t              cmd;
    rme_stat_t             stat;

    // config writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= EXPONENT_RESET[WORD_WIDTH-1:0];
            modulus_reg  <= MODULUS_RESET[WORD_WIDTH-1:0];
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_EXPONENT: exponent_reg <= cfg_data;
                REG_MODULUS:  modulus_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // sequencer: accept, special cases, base reduce, one step per exponent bit
    rme_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // operand registers, multiply and square lanes, output register
    rme_datapath #(.WORD_WIDTH(WORD_WIDTH)) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .exponent     (exponent_reg),
        .modulus      (modulus_reg),
        .base_value   (base_value),
        .result_value (result_value)
    );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import rme_pkg::*;

    localparam int WORD_W      = WORD_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 100;
    localparam int RAND_PHASES = 15;
    localparam int PHASE_ITEMS = 30;

    // indexes with no register behind them, writes there must change nothing
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_LO = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_HI = 2'd3;

    localparam logic [WORD_W-1:0] ALL_ONES = '1;
    localparam logic [WORD_W-1:0] W_ONE    = WORD_W'(1);

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       in_valid     = 1'b0;
    logic                       in_stall;
    logic [WORD_W-1:0]          base_value   = '0;
    logic                       out_valid;
    logic                       out_stall    = 1'b0;
    logic [WORD_W-1:0]          result_value;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index    = '0;
    logic [WORD_W-1:0]          cfg_data     = '0;

    // bases waiting to be driven, and results owed by the block in order
    logic [WORD_W-1:0] base_queue[$];
    logic [WORD_W-1:0] expected_results[$];

    // shadow of the key registers, starts at the reset values
    logic [WORD_W-1:0] cur_exponent = EXPONENT_RESET[WORD_W-1:0];
    logic [WORD_W-1:0] cur_modulus  = MODULUS_RESET[WORD_W-1:0];

    logic              in_xfer      = 1'b0;
    logic [WORD_W-1:0] owed_value;
    int                in_idle_pct  = 28;
    int                out_idle_pct = 28;
    int                cycle_count  = 0;
    int                fail_count   = 0;

    rsa_modular_exponentiation #(
        .WORD_WIDTH (WORD_W)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .base_value   (base_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // base ^ expo mod modu, right-to-left square and multiply,
    // products kept at double width so nothing wraps
    function automatic logic [WORD_W-1:0] power_mod(input logic [WORD_W-1:0] base,
                                                    input logic [WORD_W-1:0] expo,
                                                    input logic [WORD_W-1:0] modu);
        logic [2*WORD_W-1:0] acc;
        logic [2*WORD_W-1:0] sq;
        logic [2*WORD_W-1:0] m_wide;
        logic [WORD_W-1:0]   bits_left;
        // exponent zero wins over any modulus, even zero or one
        if (expo == '0)
            return W_ONE;
        // modulus zero or one, nothing but zero can come out
        if (modu <= W_ONE)
            return '0;
        acc       = (2*WORD_W)'(1);
        sq        = {{WORD_W{1'b0}}, base};
        m_wide    = {{WORD_W{1'b0}}, modu};
        bits_left = expo;
        while (bits_left != '0)
        begin
            if (bits_left[0])
                acc = (acc * sq) % m_wide;
            sq        = (sq * sq) % m_wide;
            bits_left = bits_left >> 1;
        end
        return acc[WORD_W-1:0];
    endfunction

    // input driver: new base only after the previous transfer or while idle
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_xfer)
            begin
                if (base_queue.size() > 0 && $urandom_range(99) >= in_idle_pct)
                begin
                    in_valid   <= 1'b1;
                    base_value <= base_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            // receiver back-pressure, independent of out_valid
            out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // monitor: all handshakes sampled at the rising edge
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        in_xfer     <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            // result transfer checked against the oldest owed result
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result_value: transfer with nothing owed, expected none actual %0d",
                           result_value);
                    fail_count++;
                end
                else
                begin
                    owed_value = expected_results.pop_front();
                    if (result_value !== owed_value)
                    begin
                        $error("result_value mismatch: expected %0d actual %0d",
                               owed_value, result_value);
                        fail_count++;
                    end
                end
            end
            // base transfer, result worked out with the keys in force now
            if (in_valid && !in_stall)
                expected_results = {expected_results,
                                    power_mod(base_value, cur_exponent, cur_modulus)};
            // register writes keep the shadow keys in step
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_EXPONENT: cur_exponent = cfg_data;
                    REG_MODULUS:  cur_modulus  = cfg_data;
                    default:      ;
                endcase
            end
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one register write, valid held until the block takes it
    task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                  input logic [WORD_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // block idle: nothing queued, nothing on the input, nothing owed
    task automatic wait_idle();
        while (base_queue.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // bases mostly full range, some reduced, some at the corners
    task automatic push_random_bases(input int count);
        logic [WORD_W-1:0] b;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9)) inside
                0:
                begin
                    case ($urandom_range(3))
                        0:       b = '0;
                        1:       b = W_ONE;
                        2:       b = cur_modulus - W_ONE;
                        default: b = ALL_ONES;
                    endcase
                end
                [1:3]:   b = WORD_W'($urandom_range(0, 32'(cur_modulus) - 1));
                default: b = WORD_W'($urandom);
            endcase
            base_queue = {base_queue, b};
        end
    endtask

    initial
    begin
        logic [WORD_W-1:0] rand_exponent;
        logic [WORD_W-1:0] rand_modulus;
        int                exp_bits;

        // reset held low at the start, the only reset of the run
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // keys straight out of reset, bases around the modulus and the extremes
        base_queue = '{'0, W_ONE, 20'd2, 20'd1048572, 20'd1048573, 20'd1048574, ALL_ONES,
                       20'h55555, 20'hAAAAA};
        wait_idle();

        // exponent zero gives one for every modulus, zero and one included
        write_register(REG_EXPONENT, '0);
        write_register(REG_MODULUS, ALL_ONES);
        base_queue = '{'0, ALL_ONES, 20'd12345};
        wait_idle();
        write_register(REG_MODULUS, '0);
        base_queue = '{20'd7};
        wait_idle();
        write_register(REG_MODULUS, W_ONE);
        base_queue = '{20'd9};
        wait_idle();

        // modulus one with a real exponent
        write_register(REG_EXPONENT, 20'd5);
        base_queue = '{20'd3, ALL_ONES};
        wait_idle();

        // modulus zero with a real exponent
        write_register(REG_MODULUS, '0);
        base_queue = '{20'd3};
        wait_idle();

        // smallest legal modulus, exponent one, base far above the modulus
        write_register(REG_MODULUS, 20'd2);
        write_register(REG_EXPONENT, W_ONE);
        base_queue = '{'0, W_ONE, ALL_ONES};
        wait_idle();

        // writes to unused indexes must leave both keys alone
        write_register(REG_UNUSED_LO, 20'h12345);
        write_register(REG_UNUSED_HI, ALL_ONES);
        base_queue = '{20'd6};
        wait_idle();

        // widest exponent and modulus, the slowest case
        write_register(REG_EXPONENT, ALL_ONES);
        write_register(REG_MODULUS, ALL_ONES);
        base_queue = '{'0, ALL_ONES, ALL_ONES - W_ONE, 20'd2};
        wait_idle();

        // random keys per phase, exponent length spread over the whole word
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            exp_bits = $urandom_range(0, WORD_W);
            if (exp_bits == 0)
                rand_exponent = '0;
            else
                rand_exponent = WORD_W'(($urandom & ((1 << exp_bits) - 1))
                                        | (1 << (exp_bits - 1)));
            case ($urandom_range(9))
                0:       rand_modulus = WORD_W'($urandom_range(2, 255));
                1:       rand_modulus = 20'd3233;
                2:       rand_modulus = WORD_W'($urandom_range(0, 1));
                default: rand_modulus = WORD_W'($urandom_range(2, ALL_ONES));
            endcase
            // one phase runs with both sides at full rate
            in_idle_pct  = (ph == 7) ? 0 : 28;
            out_idle_pct = (ph == 7) ? 0 : 28;
            write_register(REG_EXPONENT, rand_exponent);
            write_register(REG_MODULUS, rand_modulus);
            push_random_bases(PHASE_ITEMS);
            wait_idle();
        end

        // catch any stray result before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
